// ----- hw/rtl/oaht_pkg.sv -----
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and the home-slot hash for the open addressing table.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int CAPACITY = 256;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 9;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;

	// low byte of the 64-bit fnv-1a offset basis and of the prime
	localparam logic [7:0] FNV_BASIS_LO = 8'h25;
	localparam logic [7:0] FNV_PRIME_LO = 8'hb3;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_GONE  = 2'd2
	} mark_t;

	typedef enum logic {
		BK_IDLE,
		BK_LOOK
	} back_state_t;

	typedef struct packed {
		cmd_t             command;
		logic [KEY_W-1:0] lookup_key;
		logic [VAL_W-1:0] new_value;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] found_value;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// item handed from front to back, with its home slot
	typedef struct packed {
		req_t              req;
		logic [SLOT_W-1:0] home;
	} job_t;

	typedef struct packed {
		mark_t            mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// the low byte of a 64-bit fnv-1a hash depends only on low bytes,
	// so the walk runs on 8 bits: h = (h ^ b) * prime mod 256
	function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
		logic [7:0]  h;
		logic [15:0] p;
		h = FNV_BASIS_LO;
		for (int i = 0; i < KEY_W / 8; i++) begin
			p = 16'(h ^ key[8*i +: 8]) * 16'(FNV_PRIME_LO);
			h = p[7:0];
		end
		return h[SLOT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/open_addressing_hash_table.sv -----
// A clear writes its result straight to the result register; other commands probe
// P slots (1 to 256), one per cycle through the slot RAM read port, then register
// theirs. A new item is taken only once the last result has been taken; a 2-item
// input queue and the result register let both sides stall freely.
// Reset: all slots read as empty at once via per-slot valid flops, count zero.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Linear probing key/value table with fnv-1a home slot and tombstones.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  oaht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output oaht_pkg::rsp_t rsp
);
	import oaht_pkg::*;

	logic job_valid;
	logic job_ready;
	job_t job;

	// front: accept, hash, queue
	oaht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	// back: probe and update
	oaht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- hw/rtl/oaht_ram.sv -----
// ----------------------------------------------------------------------------
// oaht_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/oaht_front.sv -----
// ----------------------------------------------------------------------------
// oaht_front
// Accepts command items, computes the home slot and queues them for the back.
// ----------------------------------------------------------------------------
module oaht_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  oaht_pkg::req_t req,
	output logic          job_valid,
	input  logic          job_ready,
	output oaht_pkg::job_t job
);
	import oaht_pkg::*;

	job_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign req_ready = (fill_q != 2'd2);
	assign job_valid = (fill_q != 2'd0);
	assign job       = fifo_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = job_valid && job_ready;

	// queue storage, hash taken on the way in
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{req: req, home: home_slot(req.lookup_key)};
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2) else $error("front queue overfilled");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2) |-> !push) else $error("push into full queue");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (fill_q == $past(fill_q) + 2'd1))
		else $error("fill level missed a push");

endmodule

// ----- hw/rtl/oaht_back.sv -----
// ----------------------------------------------------------------------------
// oaht_back
// Probes the slot store one slot per cycle, applies the command, holds result.
// ----------------------------------------------------------------------------
module oaht_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  oaht_pkg::job_t job,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output oaht_pkg::rsp_t rsp
);
	import oaht_pkg::*;

	back_state_t       state_q;
	back_state_t       state_nxt;
	req_t              cur_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] n_q;
	logic              tomb_have_q;
	logic [SLOT_W-1:0] tomb_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CAPACITY-1:0] vld_q;
	logic              rvld_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	entry_t            rd_entry;
	logic [ENTRY_W-1:0] rd_raw;
	logic [SLOT_W-1:0] raddr;
	logic              we;
	logic [SLOT_W-1:0] waddr;
	entry_t            wentry;

	mark_t             m;
	logic              is_empty;
	logic              is_hit;
	logic              is_gone;
	logic              is_last;
	logic              finish;
	logic              start;
	logic              start_clear;
	logic              room;
	logic [SLOT_W-1:0] slot;
	logic              cnt_inc;
	logic              cnt_dec;
	rsp_t              rsp_nxt;

	oaht_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	assign rd_entry  = entry_t'(rd_raw);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start && !start_clear) state_nxt = BK_LOOK;
			end
			BK_LOOK: begin
				if (finish) state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// probe decision and command actions
	always_comb begin
		start       = (state_q == BK_IDLE) && job_valid && !rsp_valid_q;
		start_clear = start && (job.req.command == CMD_CLEAR);
		job_ready   = start;
		m        = rvld_q ? rd_entry.mark : MARK_EMPTY;
		is_empty = (m == MARK_EMPTY);
		is_hit   = (m == MARK_USED) && (rd_entry.key == cur_q.lookup_key);
		is_gone  = (m == MARK_GONE);
		is_last  = (n_q == SLOT_W'(CAPACITY - 1));
		finish   = (state_q == BK_LOOK) && (is_empty || is_hit || is_last);
		room     = is_empty || is_hit || tomb_have_q || is_gone;
		slot     = (!is_hit && tomb_have_q) ? tomb_q : idx_q;
		raddr    = start ? job.home : idx_q + SLOT_W'(1);
		we       = 1'b0;
		waddr    = slot;
		wentry   = '{mark: MARK_USED, key: cur_q.lookup_key, value: cur_q.new_value};
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		rsp_nxt  = '{status: ST_OK, found_value: '0, entry_count: cnt_q};
		if (start_clear) begin
			rsp_nxt.entry_count = '0;
		end else if (finish) begin
			unique case (cur_q.command)
				CMD_PUT: begin
					if (is_hit) begin
						we = 1'b1;
					end else if (room) begin
						we      = 1'b1;
						cnt_inc = 1'b1;
					end else begin
						rsp_nxt.status = ST_FULL;
					end
				end
				CMD_GET: begin
					if (is_hit) rsp_nxt.found_value = rd_entry.value;
					else rsp_nxt.status = ST_MISS;
				end
				CMD_REMOVE: begin
					if (is_hit) begin
						we      = 1'b1;
						wentry  = '{mark: MARK_GONE, key: rd_entry.key, value: rd_entry.value};
						cnt_dec = (cnt_q != '0);
					end else begin
						rsp_nxt.status = ST_MISS;
					end
				end
				default: ;
			endcase
			rsp_nxt.entry_count = cnt_q + CNT_W'(cnt_inc) - CNT_W'(cnt_dec);
		end
	end

	// control state, slot valid bits and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			vld_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rvld_q      <= 1'b0;
			tomb_have_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			rvld_q  <= vld_q[raddr];
			if (start_clear) begin
				vld_q <= '0;
				cnt_q <= '0;
			end else if (finish) begin
				if (we) vld_q[waddr] <= 1'b1;
				cnt_q <= rsp_nxt.entry_count;
			end
			if (start_clear || finish) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (start) tomb_have_q <= 1'b0;
			else if (state_q == BK_LOOK && is_gone) tomb_have_q <= 1'b1;
		end
	end

	// probe position, first tombstone, current item and result
	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= job.req;
			idx_q <= job.home;
			n_q   <= '0;
		end else if (state_q == BK_LOOK) begin
			idx_q <= idx_q + SLOT_W'(1);
			n_q   <= n_q + SLOT_W'(1);
			if (is_gone && !tomb_have_q) tomb_q <= idx_q;
		end
		if (start_clear || finish) rsp_q <= rsp_nxt;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start_clear |=> (cnt_q == '0) && (vld_q == '0)) else $error("clear left entries");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !job_ready) else $error("item taken while result pending");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.status == ST_OK || rsp_q.status == ST_MISS ||
		rsp_q.status == ST_FULL)) else $error("bad status code");

endmodule

// ----- tb/sv/tb_open_addressing_hash_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_table
// Drives put, get, remove and clear commands with random gaps and back
// pressure, predicts each response with a behavioral table model and checks
// status, found value and entry count in order.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_table;
	import oaht_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	open_addressing_hash_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// behavioral copy of the table
	mark_t            tbl_mark  [CAPACITY];
	logic [KEY_W-1:0] tbl_key   [CAPACITY];
	logic [VAL_W-1:0] tbl_value [CAPACITY];
	logic [CNT_W-1:0] tbl_count;

	req_t cmd_queue[$];
	rsp_t expected_rsp[$];
	int   errors = 0;
	bit   stim_done = 0;
	int   hold_off = 0;
	bit   req_acc = 1'b0;
	logic [KEY_W-1:0] key_pool[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// full 64-bit fnv-1a, masked to the slot index
	function automatic int unsigned fnv_home(input logic [KEY_W-1:0] key);
		logic [63:0] h;
		h = 64'd1469598103934665603;
		for (int i = 0; i < 4; i++) begin
			h = h ^ 64'(key[8*i +: 8]);
			h = h * 64'd1099511628211;
		end
		return int'(h[7:0]);
	endfunction

	function automatic rsp_t table_apply(input req_t r);
		rsp_t o;
		int unsigned start, idx, slot;
		bit hit, have_tomb, room;
		int unsigned tomb;
		o.status = ST_OK;
		o.found_value = '0;
		hit = 0; have_tomb = 0; room = 0; tomb = 0; slot = 0;
		if (r.command == CMD_CLEAR) begin
			foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
			tbl_count = '0;
		end else begin
			start = fnv_home(r.lookup_key);
			// linear probe, first tombstone remembered
			for (int n = 0; n < CAPACITY; n++) begin
				idx = (start + n) % CAPACITY;
				if (tbl_mark[idx] == MARK_EMPTY) begin
					slot = have_tomb ? tomb : idx;
					room = 1;
					break;
				end
				if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == r.lookup_key) begin
					slot = idx; room = 1; hit = 1;
					break;
				end
				if (tbl_mark[idx] == MARK_GONE && !have_tomb) begin
					have_tomb = 1; tomb = idx;
				end
				if (n == CAPACITY - 1) begin
					slot = tomb; room = have_tomb;
				end
			end
			case (r.command)
				CMD_PUT: begin
					if (hit) tbl_value[slot] = r.new_value;
					else if (room) begin
						tbl_mark[slot] = MARK_USED;
						tbl_key[slot] = r.lookup_key;
						tbl_value[slot] = r.new_value;
						tbl_count++;
					end else o.status = ST_FULL;
				end
				CMD_GET: begin
					if (hit) o.found_value = tbl_value[slot];
					else o.status = ST_MISS;
				end
				default: begin
					if (hit) begin
						tbl_mark[slot] = MARK_GONE;
						if (tbl_count > 0) tbl_count--;
					end else o.status = ST_MISS;
				end
			endcase
		end
		o.entry_count = tbl_count;
		return o;
	endfunction

	function automatic req_t mk(input cmd_t c, input logic [31:0] k, input logic [31:0] v);
		req_t r;
		r.command = c; r.lookup_key = k; r.new_value = v;
		return r;
	endfunction

	function automatic logic [31:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom();
	endfunction

	// stimulus
	initial begin
		logic [31:0] k;
		int unsigned r;
		foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
		tbl_count = '0;
		// directed: extremes, every command, misses, overwrite, tombstone reuse
		cmd_queue.push_back(mk(CMD_GET, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_REMOVE, 32'hffff_ffff, 32'h0));
		cmd_queue.push_back(mk(CMD_PUT, 32'h0, 32'hffff_ffff));
		cmd_queue.push_back(mk(CMD_PUT, 32'hffff_ffff, 32'h0));
		cmd_queue.push_back(mk(CMD_GET, 32'h0, 32'h1234));
		cmd_queue.push_back(mk(CMD_GET, 32'hffff_ffff, 32'h0));
		cmd_queue.push_back(mk(CMD_PUT, 32'h0, 32'h5555_aaaa));
		cmd_queue.push_back(mk(CMD_GET, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_REMOVE, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_GET, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_REMOVE, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_PUT, 32'haaaa_5555, 32'h0f0f_f0f0));
		cmd_queue.push_back(mk(CMD_PUT, 32'h0, 32'h1));
		cmd_queue.push_back(mk(CMD_GET, 32'haaaa_5555, 32'h0));
		cmd_queue.push_back(mk(CMD_CLEAR, 32'h0, 32'h0));
		cmd_queue.push_back(mk(CMD_GET, 32'hffff_ffff, 32'h0));
		// fill the table completely, then refuse a new key
		for (int i = 0; i < CAPACITY; i++)
			cmd_queue.push_back(mk(CMD_PUT, 32'(i * 7919 + 3), $urandom()));
		cmd_queue.push_back(mk(CMD_PUT, 32'h8000_0001, 32'h1));
		cmd_queue.push_back(mk(CMD_GET, 32'h8000_0001, 32'h0));
		cmd_queue.push_back(mk(CMD_PUT, 32'd3, 32'h77));
		cmd_queue.push_back(mk(CMD_REMOVE, 32'd10, 32'h0));
		cmd_queue.push_back(mk(CMD_GET, 32'h8000_0001, 32'h0));
		cmd_queue.push_back(mk(CMD_PUT, 32'h8000_0001, 32'h2));
		cmd_queue.push_back(mk(CMD_GET, 32'h8000_0001, 32'h0));
		cmd_queue.push_back(mk(CMD_CLEAR, 32'h0, 32'h0));
		// random: mostly puts, gets and removes on a small key pool
		for (int n = 0; n < 1020; n++) begin
			if (n % 300 == 0) begin
				key_pool.delete();
				for (int j = 0; j < 1 + $urandom_range(0, 60); j++) key_pool.push_back($urandom());
			end
			k = pick_key();
			r = $urandom_range(0, 99);
			if (r < 45) cmd_queue.push_back(mk(CMD_PUT, k, $urandom()));
			else if (r < 75) cmd_queue.push_back(mk(CMD_GET, k, $urandom()));
			else if (r < 99) cmd_queue.push_back(mk(CMD_REMOVE, k, $urandom()));
			else cmd_queue.push_back(mk(CMD_CLEAR, k, $urandom()));
		end
		stim_done = 1;
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: request side
	int req_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap <= $urandom_range(0, 18);
		end else if (req_valid && !req_acc) begin
			// hold item until accepted
		end else if (req_gap > 0) begin
			req_valid <= 1'b0;
			req_gap <= req_gap - 1;
		end else if (cmd_queue.size() > 0) begin
			req_valid <= 1'b1;
			req <= cmd_queue.pop_front();
			req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
		end else begin
			req_valid <= 1'b0;
		end
	end

	// capture accepted items and predict their responses
	always @(posedge clk) begin
		req_acc <= arst_n && req_valid && req_ready;
		if (arst_n && req_valid && req_ready)
			expected_rsp.push_back(table_apply(req));
	end

	// response side stall, with one long hold-off
	int rsp_gap = 0;
	int accepted = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap <= 0;
		end else if (accepted == 400 && hold_off == 0) begin
			hold_off <= 1;
			rsp_ready <= 1'b0;
			rsp_gap <= 300;
		end else if (rsp_gap > 0) begin
			rsp_ready <= 1'b0;
			rsp_gap <= rsp_gap - 1;
		end else if (rsp_ready && rsp_valid) begin
			if ($urandom_range(0, 2) == 0) rsp_ready <= 1'b1;
			else begin
				rsp_ready <= 1'b0;
				rsp_gap <= $urandom_range(0, 18);
			end
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// monitor: compare each response with the oldest prediction
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			accepted <= accepted + 1;
			if (expected_rsp.size() == 0) begin
				$error("unexpected response: %p", rsp);
				errors++;
			end else begin
				exp_rsp = expected_rsp.pop_front();
				if (rsp.status !== exp_rsp.status) begin
					$error("status expected %0d actual %0d", exp_rsp.status, rsp.status);
					errors++;
				end
				if (rsp.found_value !== exp_rsp.found_value) begin
					$error("found_value expected %h actual %h",
						exp_rsp.found_value, rsp.found_value);
					errors++;
				end
				if (rsp.entry_count !== exp_rsp.entry_count) begin
					$error("entry_count expected %0d actual %0d",
						exp_rsp.entry_count, rsp.entry_count);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (arst_n && cmd_queue.size() == 0 && !req_valid);
		wait (expected_rsp.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// timeout
	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
